FILE: hdl/byte_histogram_core_assert.svh
// Assertion macros for the byte histogram core.
`ifndef BYTE_HISTOGRAM_CORE_ASSERT_SVH
`define BYTE_HISTOGRAM_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BHC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("byte_histogram_core: assertion failed");
`define BHC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte_histogram_core: implication failed");
`else
`define BHC_ASSERT(lbl, clk, rst, prop)
`define BHC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/bhist_pkg.sv
// Types and constants shared by the byte histogram core modules.
`default_nettype none
package bhist_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = 8;
  localparam int POS_W       = 9;
  localparam int GRP_W       = 4;
  localparam int LANE_W      = 4;
  localparam int NUM_GRPS    = 16;
  localparam int LANES       = 16;
  localparam int COUNT_OUT_W = 32;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_FIND,
    ST_PICK,
    ST_READ
  } bhist_state_t;

  typedef struct packed {
    logic             opcode;
    logic [BIN_W-1:0] byte_value;
  } bhist_in_t;

  typedef struct packed {
    logic [BIN_W-1:0]       bin;
    logic [COUNT_OUT_W-1:0] count;
    logic                   found;
    logic                   last;
  } bhist_out_t;

  typedef struct packed {
    logic             set_flag;
    logic             clr_flag;
    logic [BIN_W-1:0] bin;
  } bhist_flag_cmd_t;

  typedef struct packed {
    logic             grp_valid;
    logic [GRP_W-1:0] grp;
    logic             hit_valid;
    logic [BIN_W-1:0] hit_bin;
    logic             bin_flag;
  } bhist_scan_stat_t;

endpackage
`default_nettype wire

FILE: hdl/bhist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bhist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bhist_scan.sv
// Nonzero-bin bitmap with two-level search for the next occupied bin.
`default_nettype none
module bhist_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  bhist_pkg::bhist_flag_cmd_t    cmd,
  input  logic [bhist_pkg::POS_W-1:0]   scan_pos,
  input  logic [bhist_pkg::GRP_W-1:0]   grp_sel,
  output bhist_pkg::bhist_scan_stat_t   stat
);
  import bhist_pkg::*;

  logic [NUM_BINS-1:0] flags;
  logic [NUM_GRPS-1:0] grp_any;
  logic [NUM_GRPS-1:0] grp_cand;
  logic [LANES-1:0]    lo_mask;
  logic [LANES-1:0]    pick_bits;
  logic [GRP_W-1:0]    pos_grp;
  logic [LANE_W-1:0]   pos_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      if (cmd.set_flag) begin
        flags[cmd.bin] <= 1'b1;
      end
      if (cmd.clr_flag) begin
        flags[cmd.bin] <= 1'b0;
      end
    end
  end

  assign pos_grp  = scan_pos[BIN_W-1:LANE_W];
  assign pos_lane = scan_pos[LANE_W-1:0];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      lo_mask[j] = (LANE_W'(j) >= pos_lane);
    end
    for (int g = 0; g < NUM_GRPS; g++) begin
      grp_any[g]  = |flags[g*LANES +: LANES];
      grp_cand[g] = !scan_pos[POS_W-1] &&
                    (((GRP_W'(g) > pos_grp) && grp_any[g]) ||
                     ((GRP_W'(g) == pos_grp) && |(flags[g*LANES +: LANES] & lo_mask)));
    end

    stat.grp_valid = |grp_cand;
    stat.grp       = '0;
    for (int g = NUM_GRPS - 1; g >= 0; g--) begin
      if (grp_cand[g]) begin
        stat.grp = GRP_W'(g);
      end
    end

    pick_bits = flags[grp_sel*LANES +: LANES];
    if (grp_sel == pos_grp) begin
      pick_bits = pick_bits & lo_mask;
    end
    stat.hit_valid = |pick_bits;
    stat.hit_bin   = {grp_sel, {LANE_W{1'b0}}};
    for (int j = LANES - 1; j >= 0; j--) begin
      if (pick_bits[j]) begin
        stat.hit_bin = {grp_sel, LANE_W'(j)};
      end
    end
    stat.bin_flag = flags[cmd.bin];
  end

endmodule
`default_nettype wire

FILE: hdl/byte_histogram_core.sv
// Byte frequency histogram core with drain-on-read of nonzero bins.
// The input channel takes one word per item: a count word adds one to the
// saturating counter of its byte, a drain word returns the next nonzero bin
// at or above the scan pointer and clears that counter. Counters live in a
// RAM; a bitmap of nonzero bins marks which RAM entries hold live data.
// A count word takes a RAM read, then a write back.
// A drain word goes through group search, bin search with RAM read, then the
// result register loads. A drain that finds nothing loads a not-found word
// straight from the group search and rewinds the scan pointer to bin zero.
// Either kind of drain result waits while the output is stalled. The block
// accepts a new word only in its idle state, so each word is finished first.
// Reset clears the bitmap, so all counters read as zero at once.
// The result register lets a new word be accepted while a result still waits;
// a drain that completes while the receiver stalls holds in place until the
// output register frees up.
`default_nettype none
`include "byte_histogram_core_assert.svh"
module byte_histogram_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bhist_pkg::bhist_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bhist_pkg::bhist_out_t  out_data
);
  import bhist_pkg::*;

  bhist_state_t     state, state_next;
  bhist_flag_cmd_t  cmd;
  bhist_scan_stat_t stat;

  logic [POS_W-1:0] scan_pos, scan_pos_next;
  logic [GRP_W-1:0] grp, grp_next;
  logic [BIN_W-1:0] cur_bin, cur_bin_next;

  logic                   mem_we, mem_re;
  logic [BIN_W-1:0]       mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata, old_count;
  logic [COUNT_OUT_W-1:0] count_out;

  logic       out_free, out_load;
  bhist_out_t out_next, out_reg;

  bhist_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_bin),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bhist_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .scan_pos (scan_pos),
    .grp_sel  (grp),
    .stat     (stat)
  );

  generate
    if (COUNT_WIDTH > COUNT_OUT_W) begin : g_sat_out
      assign count_out = (|mem_rdata[COUNT_WIDTH-1:COUNT_OUT_W]) ? '1 :
                         mem_rdata[COUNT_OUT_W-1:0];
    end else begin : g_ext_out
      assign count_out = COUNT_OUT_W'(mem_rdata);
    end
  endgenerate

  assign old_count = stat.bin_flag ? mem_rdata : '0;
  assign mem_wdata = (old_count == '1) ? old_count : old_count + COUNT_WIDTH'(1);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.opcode == OP_COUNT) ? ST_COUNT : ST_FIND;
        end
      end
      ST_COUNT: state_next = ST_IDLE;
      ST_FIND: begin
        if (stat.grp_valid) begin
          state_next = ST_PICK;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_PICK: state_next = ST_READ;
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = in_data.byte_value;
    mem_we        = 1'b0;
    cmd.set_flag  = 1'b0;
    cmd.clr_flag  = 1'b0;
    cmd.bin       = cur_bin;
    out_load      = 1'b0;
    out_next      = '0;
    scan_pos_next = scan_pos;
    grp_next      = grp;
    cur_bin_next  = cur_bin;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        mem_re       = in_valid;
        cur_bin_next = in_data.byte_value;
      end
      ST_COUNT: begin
        mem_we       = 1'b1;
        cmd.set_flag = 1'b1;
      end
      ST_FIND: begin
        grp_next = stat.grp;
        if (!stat.grp_valid && out_free) begin
          out_load      = 1'b1;
          out_next.last = 1'b1;
          scan_pos_next = '0;
        end
      end
      ST_PICK: begin
        mem_re        = 1'b1;
        mem_raddr     = stat.hit_bin;
        cur_bin_next  = stat.hit_bin;
        scan_pos_next = POS_W'(stat.hit_bin) + POS_W'(1);
      end
      ST_READ: begin
        cmd.clr_flag = 1'b1;
        if (out_free) begin
          out_load       = 1'b1;
          out_next.bin   = cur_bin;
          out_next.count = count_out;
          out_next.found = 1'b1;
          out_next.last  = !stat.grp_valid;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_pos <= scan_pos_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    grp     <= grp_next;
    cur_bin <= cur_bin_next;
    if (out_load) begin
      out_reg <= out_next;
    end
  end

  assign out_data = out_reg;

  `BHC_ASSERT(a_count_writes, clk, rst, (in_valid && in_ready && in_data.opcode == OP_COUNT) |=> mem_we)
  `BHC_ASSERT_IMP(a_found_nonzero, clk, rst, out_valid && out_data.found, out_data.count != '0)
  `BHC_ASSERT(a_miss_rewinds, clk, rst, (out_load && !out_next.found) |=> (scan_pos == '0))
  `BHC_ASSERT_IMP(a_pick_hits, clk, rst, state == ST_PICK, stat.hit_valid)

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the byte histogram core: directed table, then random data sets.
`timescale 1ns / 1ps
module testbench;
  import bhist_pkg::*;

  localparam int ITEMS = 1200;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int NUM_DIRECTED = 25;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    bhist_in_t  word;
    logic       typed;
    bhist_out_t result;
  } dir_row_t;

  localparam bhist_out_t NONE_LEFT = '{8'h00, 32'd0, 1'b0, 1'b1};
  localparam bhist_out_t UNTYPED = '0;

  localparam dir_row_t DIR_ROWS [NUM_DIRECTED] = '{
    '{'{OP_DRAIN, 8'h00}, 1'b1, NONE_LEFT},
    '{'{OP_COUNT, 8'h00}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'hFF}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'hFF}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'hFF}, 1'b1, '{8'h00, 32'd1, 1'b1, 1'b0}},
    '{'{OP_DRAIN, 8'h00}, 1'b1, '{8'hFF, 32'd2, 1'b1, 1'b1}},
    '{'{OP_DRAIN, 8'h00}, 1'b1, NONE_LEFT},
    '{'{OP_COUNT, 8'h80}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'h7F}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'h55}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'hAA}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'h01}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b1, NONE_LEFT},
    '{'{OP_DRAIN, 8'h00}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b1, NONE_LEFT},
    '{'{OP_COUNT, 8'h33}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'h33}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'h33}, 1'b0, UNTYPED},
    '{'{OP_COUNT, 8'h33}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b0, UNTYPED},
    '{'{OP_DRAIN, 8'h00}, 1'b1, NONE_LEFT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bhist_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bhist_out_t out_data;

  logic [COUNT_OUT_W-1:0] tally [NUM_BINS];
  int drain_ptr;
  logic set_drained;
  bhist_out_t bin_reports_due [$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic hold_req = 1'b0;
  int count_words;
  int drain_words;
  int reports_seen;
  int empty_reports;
  int errors;
  int quiet_cycles;

  byte_histogram_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic tally_word(input bhist_in_t w, output bhist_out_t r);
    int hit;
    int b;
    r = '0;
    if (w.opcode == OP_COUNT) begin
      if (tally[w.byte_value] != '1) begin
        tally[w.byte_value] = tally[w.byte_value] + 1;
      end
      return 1'b0;
    end
    hit = NUM_BINS;
    for (b = drain_ptr; b < NUM_BINS; b++) begin
      if (tally[b] != 0) begin
        hit = b;
        break;
      end
    end
    if (hit == NUM_BINS) begin
      drain_ptr = 0;
      r.last = 1'b1;
      set_drained = 1'b1;
      return 1'b1;
    end
    r.bin = 8'(hit);
    r.count = tally[hit];
    r.found = 1'b1;
    tally[hit] = '0;
    drain_ptr = hit + 1;
    r.last = 1'b1;
    for (b = hit + 1; b < NUM_BINS; b++) begin
      if (tally[b] != 0) begin
        r.last = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_word(input bhist_in_t w, input logic typed, input bhist_out_t given);
    bhist_out_t r;
    int gap_pct;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    if (tally_word(w, r)) begin
      bin_reports_due.push_back(typed ? given : r);
    end
    if (w.opcode == OP_DRAIN) begin
      drain_words++;
    end else begin
      count_words++;
    end
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      gap_pct = (idle_mode == IDLE_SENDER) ? 61 : 7;
      while ($urandom_range(99) < gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_reports();
    in_valid <= 1'b0;
    while (bin_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (idle_mode == IDLE_RECEIVER) begin
        out_ready <= ($urandom_range(99) >= 61);
      end else if (idle_mode == IDLE_BOTH) begin
        out_ready <= ($urandom_range(99) >= 7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    bhist_out_t want;
    if (!rst && out_valid && out_ready) begin
      reports_seen++;
      if (!out_data.found) begin
        empty_reports++;
      end
      if (bin_reports_due.size() == 0) begin
        $display("%0t: word expected none got %p", $time, out_data);
        errors++;
      end else begin
        want = bin_reports_due.pop_front();
        check_field("bin", want.bin, out_data.bin);
        check_field("count", want.count, out_data.count);
        check_field("found", want.found, out_data.found);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no word moved in %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bhist_in_t w;
    logic [BIN_W-1:0] pool [4];
    idle_mode_t next_mode;
    int n;
    for (int b = 0; b < NUM_BINS; b++) begin
      tally[b] = '0;
    end
    drain_ptr = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(DIR_ROWS[i].word, DIR_ROWS[i].typed, DIR_ROWS[i].result);
    end

    // The receiver holds off while the sender keeps offering, so the core backs up.
    wait_all_reports();
    hold_req = 1'b1;

    while (count_words + drain_words < ITEMS) begin
      next_mode = idle_mode_t'((count_words + drain_words - NUM_DIRECTED) * 4
                               / (ITEMS - NUM_DIRECTED));
      if (next_mode != idle_mode) begin
        wait_all_reports();
        idle_mode = next_mode;
      end
      if ($urandom_range(99) < 80) begin
        for (int p = 0; p < 4; p++) begin
          pool[p] = 8'($urandom_range(255));
        end
        n = $urandom_range(1, 24);
        repeat (n) begin
          w.opcode = OP_COUNT;
          w.byte_value = ($urandom_range(3) != 0) ? pool[$urandom_range(3)]
                                                  : 8'($urandom_range(255));
          send_word(w, 1'b0, UNTYPED);
        end
        set_drained = 1'b0;
        while (!set_drained) begin
          w.opcode = ($urandom_range(9) == 0) ? OP_COUNT : OP_DRAIN;
          w.byte_value = 8'($urandom_range(255));
          send_word(w, 1'b0, UNTYPED);
        end
      end else begin
        repeat (8) begin
          w.opcode = ($urandom_range(1) == 0) ? OP_COUNT : OP_DRAIN;
          w.byte_value = 8'($urandom_range(255));
          send_word(w, 1'b0, UNTYPED);
        end
      end
    end

    wait_all_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d count words and %0d drain words; checked %0d results, %0d empty.",
             count_words, drain_words, reports_seen, empty_reports);
    $display("Idling covered none, sender, receiver and both, plus one long receiver hold.");
    if (errors == 0 && bin_reports_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: byte_histogram_core.f
+incdir+hdl
hdl/bhist_pkg.sv
hdl/bhist_ram.sv
hdl/bhist_scan.sv
hdl/byte_histogram_core.sv
dv/testbench.sv
